// ===== rtl/sha256_byte_stream_hasher_defines.svh =====
// assertion macros for the hasher sequencer (shb_ctrl)
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// same-cycle implication, held off while in reset
`define SHB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off while in reset
`define SHB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/shb_pkg.sv =====
package shb_pkg;

	// byte source for the block shift line
	typedef enum logic [1:0] {
		BSEL_DATA,
		BSEL_PAD,
		BSEL_ZERO,
		BSEL_LEN
	} shb_bsel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic       push;
		shb_bsel_t  bsel;
		logic       count_len;
		logic       load_work;
		logic       round;
		logic [5:0] rnd;
		logic       add_chain;
		logic       init;
		logic [2:0] word_sel;
	} shb_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic full;
		logic ge56;
	} shb_status_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// initial hash values
	function automatic logic [31:0] shb_iv(input logic [2:0] idx);
		logic [31:0] v;
		case (idx)
			3'd0: v = 32'h6a09e667;
			3'd1: v = 32'hbb67ae85;
			3'd2: v = 32'h3c6ef372;
			3'd3: v = 32'ha54ff53a;
			3'd4: v = 32'h510e527f;
			3'd5: v = 32'h9b05688c;
			3'd6: v = 32'h1f83d9ab;
			default: v = 32'h5be0cd19;
		endcase
		return v;
	endfunction

	// round constants
	function automatic logic [31:0] shb_k(input logic [5:0] idx);
		logic [31:0] v;
		case (idx)
			6'd0: v = 32'h428a2f98;  6'd1: v = 32'h71374491;
			6'd2: v = 32'hb5c0fbcf;  6'd3: v = 32'he9b5dba5;
			6'd4: v = 32'h3956c25b;  6'd5: v = 32'h59f111f1;
			6'd6: v = 32'h923f82a4;  6'd7: v = 32'hab1c5ed5;
			6'd8: v = 32'hd807aa98;  6'd9: v = 32'h12835b01;
			6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
			6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
			6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
			6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
			6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
			6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
			6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
			6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
			6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
			6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
			6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
			6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
			6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
			6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
			6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
			6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
			6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
			6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
			6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
			6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
			6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
			6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
			6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
			6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
			6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
			6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
			6'd62: v = 32'hbef9a3f7;
			default: v = 32'hc67178f2;
		endcase
		return v;
	endfunction

	// round functions
	function automatic logic [31:0] shb_big0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] shb_big1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	// schedule functions
	function automatic logic [31:0] shb_sg0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] shb_sg1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// ===== rtl/shb_datapath.sv =====
module shb_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  shb_pkg::shb_cmd_t    cmd,
	input  logic [7:0]           data_byte,
	output shb_pkg::shb_status_t status,
	output logic [31:0]          digest_word
);
	import shb_pkg::*;

	logic [511:0] win_q;
	logic [31:0]  work_q [8];
	logic [31:0]  chain_q [8];
	logic [5:0]   cnt_q;
	logic [63:0]  len_q;

	logic [7:0]   push_byte;
	logic [31:0]  w0, w1, w9, w14, w_new;
	logic [31:0]  t1, t2, ch, maj;

	// byte source selection
	always_comb begin
		case (cmd.bsel)
			BSEL_DATA: push_byte = data_byte;
			BSEL_PAD:  push_byte = PAD_BYTE;
			BSEL_LEN:  push_byte = len_q[{~cnt_q[2:0], 3'b000} +: 8];
			default:   push_byte = 8'h00;
		endcase
	end

	// schedule taps, oldest word at the top of the window
	assign w0  = win_q[511:480];
	assign w1  = win_q[479:448];
	assign w9  = win_q[223:192];
	assign w14 = win_q[63:32];
	assign w_new = shb_sg1(w14) + w9 + shb_sg0(w1) + w0;

	// one compression round
	assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
	assign t1  = work_q[7] + shb_big1(work_q[4]) + ch + shb_k(cmd.rnd) + w0;
	assign t2  = shb_big0(work_q[0]) + maj;

	// byte window doubling as schedule shift line, and working variables
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			win_q <= {win_q[503:0], push_byte};
		end else if (cmd.round) begin
			win_q <= {win_q[479:0], w_new};
		end
		if (cmd.load_work) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (cmd.round) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end
	end

	// chaining words, fill count and bit length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= shb_iv(3'(i));
			end
			cnt_q <= '0;
			len_q <= '0;
		end else begin
			if (cmd.init) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= shb_iv(3'(i));
				end
				cnt_q <= '0;
				len_q <= '0;
			end else begin
				if (cmd.add_chain) begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + work_q[i];
					end
				end
				if (cmd.push) begin
					cnt_q <= cnt_q + 6'd1;
				end
				if (cmd.count_len) begin
					len_q <= len_q + 64'd8;
				end
			end
		end
	end

	assign status.full  = (cnt_q == 6'd63);
	assign status.ge56  = (cnt_q[5:3] == 3'b111);
	assign digest_word  = chain_q[cmd.word_sel];

endmodule

// ===== rtl/shb_ctrl.sv =====
`include "sha256_byte_stream_hasher_defines.svh"

module shb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 has_byte,
	input  logic                 is_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           word_index,
	output logic                 last_word,
	output shb_pkg::shb_cmd_t    cmd,
	input  shb_pkg::shb_status_t status
);
	import shb_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_LOAD,
		S_ROUND,
		S_ADD,
		S_OUT
	} state_t;

	state_t     state_q, after_q;
	logic       pad_first_q, len_ok_q;
	logic [5:0] rnd_q;
	logic [2:0] oidx_q;
	logic       len_ok_now;
	logic       pad_flush;
	logic       digest_end;

	// whether the length field fits in the block now being padded
	assign len_ok_now = pad_first_q ? !status.ge56 : len_ok_q;

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.bsel      = BSEL_DATA;
		cmd.rnd       = rnd_q;
		cmd.word_sel  = oidx_q;
		case (state_q)
			S_IDLE: begin
				cmd.push      = in_valid && has_byte;
				cmd.count_len = in_valid && has_byte;
			end
			S_PAD: begin
				cmd.push = 1'b1;
				if (pad_first_q) begin
					cmd.bsel = BSEL_PAD;
				end else if (len_ok_q && status.ge56) begin
					cmd.bsel = BSEL_LEN;
				end else begin
					cmd.bsel = BSEL_ZERO;
				end
			end
			S_LOAD:  cmd.load_work = 1'b1;
			S_ROUND: cmd.round = 1'b1;
			S_ADD:   cmd.add_chain = 1'b1;
			S_OUT:   cmd.init = out_ready && (oidx_q == 3'd7);
			default: cmd.push = 1'b0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			after_q     <= S_IDLE;
			pad_first_q <= 1'b0;
			len_ok_q    <= 1'b0;
			rnd_q       <= '0;
			oidx_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (has_byte && status.full) begin
							state_q     <= S_LOAD;
							after_q     <= is_last ? S_PAD : S_IDLE;
							pad_first_q <= is_last;
						end else if (is_last) begin
							state_q     <= S_PAD;
							pad_first_q <= 1'b1;
						end
					end
				end
				S_PAD: begin
					pad_first_q <= 1'b0;
					if (status.full) begin
						state_q <= S_LOAD;
						if (len_ok_now) begin
							after_q <= S_OUT;
						end else begin
							after_q <= S_PAD;
						end
					end
					// length goes in the next block once this one is flushed without it
					if (status.full && !len_ok_now) begin
						len_ok_q <= 1'b1;
					end else if (pad_first_q) begin
						len_ok_q <= !status.ge56;
					end
				end
				S_LOAD: begin
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					oidx_q  <= '0;
					state_q <= after_q;
				end
				S_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = (state_q == S_OUT);
	assign word_index = oidx_q;
	assign last_word  = (oidx_q == 3'd7);

	// conditions watched by the checks
	assign pad_flush  = (state_q == S_PAD) && status.full;
	assign digest_end = out_valid && out_ready && last_word;

	// checks
	`SHB_ASSERT_NOW(a_no_overlap, clk, arst_n, in_ready, !out_valid, "input and output both open")
	`SHB_ASSERT_NEXT(a_round_start, clk, arst_n, state_q == S_LOAD, rnd_q == 6'd0, "rounds not cleared")
	`SHB_ASSERT_NEXT(a_pad_full, clk, arst_n, pad_flush, state_q == S_LOAD, "padded block not compressed")
	`SHB_ASSERT_NEXT(a_digest_done, clk, arst_n, digest_end, in_ready, "no return to idle after digest")

endmodule

// ===== rtl/sha256_byte_stream_hasher.sv =====
// a byte item without block completion is taken whenever the hasher is idle; the 64th byte of a block
// starts a compression (load, 64 rounds at one round per cycle, chain add)
// intake is held off (in_ready low) while a block is padded or compressed or the digest is sent
// a last item adds padding and one or two compressions, then 8 digest words
// reset: async active low, chaining words to the initial values, counts and length to zero
module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import shb_pkg::*;

	shb_cmd_t    cmd;
	shb_status_t status;

	// sequencer
	shb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.has_byte   (has_byte),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.word_index (word_index),
		.last_word  (last_word),
		.cmd        (cmd),
		.status     (status)
	);

	// hashing datapath
	shb_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.status      (status),
		.digest_word (digest_word)
	);

endmodule

// ===== bench/sha256_digest_checker.sv =====
// watches both channels of the hasher, predicts every digest word and compares
module sha256_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        is_last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          mismatches,
	output int          words_due,
	output int          words_checked
);

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam int LEN_AT = 56;

	localparam logic [0:7][31:0] CHAIN_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [0:63][31:0] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_entry_t;

	// predicted hasher state
	logic [7:0]    msg_block [64];
	int            fill_level;
	logic [63:0]   msg_bits;
	logic [31:0]   chain_h [8];
	digest_entry_t digest_due [$];

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void restart_message();
		fill_level = 0;
		msg_bits = 64'd0;
		for (int k = 0; k < 8; k++)
			chain_h[k] = CHAIN_IV[k];
	endfunction

	// one 64-round compression of the buffered block into the chaining words
	function automatic void compress_buffer();
		logic [31:0] sched [64];
		logic [31:0] wv [8];
		logic [31:0] s0, s1, t1, t2;
		for (int r = 0; r < 16; r++)
			sched[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
		for (int r = 16; r < 64; r++) begin
			s0 = ror32(sched[r-15], 7) ^ ror32(sched[r-15], 18) ^ (sched[r-15] >> 3);
			s1 = ror32(sched[r-2], 17) ^ ror32(sched[r-2], 19) ^ (sched[r-2] >> 10);
			sched[r] = s1 + sched[r-7] + s0 + sched[r-16];
		end
		for (int k = 0; k < 8; k++)
			wv[k] = chain_h[k];
		for (int r = 0; r < 64; r++) begin
			s1 = ror32(wv[4], 6) ^ ror32(wv[4], 11) ^ ror32(wv[4], 25);
			t1 = wv[7] + s1 + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + ROUND_K[r] + sched[r];
			s0 = ror32(wv[0], 2) ^ ror32(wv[0], 13) ^ ror32(wv[0], 22);
			t2 = s0 + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
			for (int k = 7; k > 0; k--)
				wv[k] = wv[k-1];
			// the shifted-in word at slot 4 is the old slot 3
			wv[4] = wv[4] + t1;
			wv[0] = t1 + t2;
		end
		for (int k = 0; k < 8; k++)
			chain_h[k] = chain_h[k] + wv[k];
	endfunction

	// take one accepted item; a closing item queues the eight digest words
	function automatic void absorb_item(input logic [7:0] b, input logic hb, input logic fin);
		int pos;
		digest_entry_t e;
		if (hb) begin
			msg_block[fill_level] = b;
			fill_level++;
			msg_bits = msg_bits + 64'd8;
			if (fill_level == 64) begin
				compress_buffer();
				fill_level = 0;
			end
		end
		if (fin) begin
			pos = fill_level;
			msg_block[pos] = PAD_MARK;
			pos++;
			// no room for the length: pad out and take an extra block
			if (pos > LEN_AT) begin
				while (pos < 64) begin
					msg_block[pos] = 8'h00;
					pos++;
				end
				compress_buffer();
				pos = 0;
			end
			while (pos < LEN_AT) begin
				msg_block[pos] = 8'h00;
				pos++;
			end
			for (int k = 0; k < 8; k++)
				msg_block[LEN_AT + k] = msg_bits[63 - 8*k -: 8];
			compress_buffer();
			for (int k = 0; k < 8; k++) begin
				e.word = chain_h[k];
				e.index = 3'(k);
				e.last = (k == 7);
				digest_due.push_back(e);
			end
			restart_message();
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	// compare results first, then predict from the item taken at the same edge
	always @(posedge clk or negedge arst_n) begin : watch
		digest_entry_t want;
		if (!arst_n) begin
			restart_message();
			digest_due.delete();
			words_due <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (digest_due.size() == 0) begin
					report_mismatch("digest word with none pending", digest_word, 32'h0);
				end else begin
					want = digest_due.pop_front();
					if (digest_word !== want.word)
						report_mismatch("digest_word", digest_word, want.word);
					if (word_index !== want.index)
						report_mismatch("word_index", 32'(word_index), 32'(want.index));
					if (last_word !== want.last)
						report_mismatch("last_word", 32'(last_word), 32'(want.last));
					words_checked <= words_checked + 1;
				end
			end
			if (in_valid && in_ready)
				absorb_item(data_byte, has_byte, is_last);
			words_due <= digest_due.size();
		end
	end

endmodule

// ===== bench/sha256_byte_stream_hasher_tb.sv =====
module sha256_byte_stream_hasher_tb;

	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        has_byte;
	logic        is_last;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	int mismatches;
	int words_due;
	int words_checked;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_request;
	int items_sent;
	int messages_sent;
	int msg_len;
	int longest_msg;

	sha256_byte_stream_hasher DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.has_byte   (has_byte),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digest_word(digest_word),
		.word_index (word_index),
		.last_word  (last_word)
	);

	sha256_digest_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.has_byte     (has_byte),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word),
		.mismatches   (mismatches),
		.words_due    (words_due),
		.words_checked(words_checked)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// offer one item, idling at random first, and wait until it is taken
	task automatic send_item(input logic [7:0] b, input logic hb, input logic fin);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		has_byte <= hb;
		is_last <= fin;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (hb)
			msg_len++;
		if (fin) begin
			messages_sent++;
			if (msg_len > longest_msg)
				longest_msg = msg_len;
			msg_len = 0;
		end
	endtask

	// drop valid once no item follows straight away
	task automatic go_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// one message with random bytes, stray empty items and either way of closing
	task automatic send_message(input int len);
		logic close_on_byte;
		close_on_byte = (len > 0) && ($urandom_range(1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
		end
		if (!close_on_byte)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// mostly short messages, now and then one at a padding boundary
	task automatic run_phase(input int target);
		int len;
		while (items_sent < target) begin
			if ($urandom_range(9) == 0) begin
				case ($urandom_range(3))
					0: len = 55;
					1: len = 56;
					2: len = 63;
					default: len = 64;
				endcase
			end else begin
				len = $urandom_range(12);
			end
			send_message(len);
		end
	endtask

	// receiver: random back-pressure plus requested long hold-offs
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// ends the run when nothing moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
		$display("sha256_byte_stream_hasher_tb: done, errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		has_byte = 1'b0;
		is_last = 1'b0;
		hold_request = 0;
		send_idle_pct = 23;
		recv_idle_pct = 87;
		items_sent = 0;
		messages_sent = 0;
		msg_len = 0;
		longest_msg = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty message, a three-byte message closed on its byte
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		// stray empty item between messages, then one with a stray inside
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'ha5, 1'b0, 1'b0);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h3c, 1'b0, 1'b1);
		// single-byte messages of ff, 00 and the pad byte value 80, one after another
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'h80, 1'b1, 1'b1);

		// sender lightly idle, receiver mostly stalled
		run_phase(40);
		// sender waits until every digest word has come back
		go_quiet();
		while (words_due != 0)
			@(posedge clk);

		// sender mostly idle, receiver lightly stalled
		send_idle_pct = 87;
		recv_idle_pct = 23;
		send_message(56);
		run_phase(110);

		// no idling; a long receiver hold-off while messages keep coming
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 600;
		for (int m = 0; m < 4; m++)
			send_message(6);
		send_message(64);
		run_phase(210);

		go_quiet();
		while (words_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d items in %0d messages (longest %0d bytes), %0d digest words",
			items_sent, messages_sent, longest_msg, words_checked);
		if (mismatches == 0 && words_due == 0) begin
			$display("sha256_byte_stream_hasher_tb: done, clean");
		end else begin
			$display("sha256_byte_stream_hasher_tb: done, errors");
		end
		$finish;
	end

endmodule
